FILE: hdl/bilinear_image_scaler_unit_defines.svh
// Assertion macros shared by the bilinear scaler RTL.
`ifndef BILINEAR_IMAGE_SCALER_UNIT_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_UNIT_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define BIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bis_pkg.sv
// Shared constants, codes and control types of the bilinear scaler.
package bis_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_DIM_W  = 9;
  localparam int STEP_W     = 24;
  localparam int CFG_IDX_W  = 2;

  localparam int MAX_SRC_DIM_DEF = 256;
  localparam int MAX_DST_DIM_DEF = 1024;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [STEP_W-1:0]    STEP_RST   = 24'd65536;
  localparam logic                 ROUND_RST  = 1'b0;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND      = 2'd3;

  // Neighbor read order: top-left, top-right, bottom-left, bottom-right.
  localparam logic [1:0] NB_00 = 2'd0;
  localparam logic [1:0] NB_01 = 2'd1;
  localparam logic [1:0] NB_10 = 2'd2;
  localparam logic [1:0] NB_11 = 2'd3;

  typedef struct packed {
    logic mul_en;
    logic clamp_en;
    logic shift_en;
    logic top_en;
    logic bot_en;
    logic acc0_en;
    logic acc1_en;
  } bis_ctl_t;

endpackage

FILE: hdl/bis_frame_mem.sv
// Source frame store: synchronous memory with one write and one read port.
module bis_frame_mem import bis_pkg::*; #(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [PIX_W-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [PIX_W-1:0]  rd_data_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [PIX_W-1:0] mem_r [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem_r[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en_i) begin
      rd_data_r <= mem_r[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_r;

endmodule

FILE: hdl/bis_addr_gen.sv
// Source position mapping, border clamping and neighbor address selection.
module bis_addr_gen import bis_pkg::*; #(
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = MAX_DST_DIM_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int SIDX_W     = $clog2(MAX_SRC_DIM),
  localparam int DST_W      = $clog2(MAX_DST_DIM)
) (
  input  logic                   clk,
  input  bis_ctl_t               ctl_i,
  input  logic [DST_W-1:0]       dst_col_i,
  input  logic [DST_W-1:0]       dst_row_i,
  input  logic [STEP_W-1:0]      step_i,
  input  logic [CFG_DIM_W-1:0]   width_i,
  input  logic [CFG_DIM_W-1:0]   height_i,
  input  logic [1:0]             nb_sel_i,
  output logic [2*SIDX_W-1:0]    rd_addr_o,
  output logic [FRAC_BITS-1:0]   fx_o,
  output logic [FRAC_BITS-1:0]   fy_o
);

  localparam int POS_W = DST_W + STEP_W;
  localparam int IX_W  = POS_W - FRAC_BITS;
  localparam int CMP_W = (IX_W + 1 > SIDX_W) ? IX_W + 1 : SIDX_W;

  logic [POS_W-1:0]     posx_r, posy_r;
  logic [SIDX_W-1:0]    x0_r, x1_r, y0_r, y1_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic [SIDX_W-1:0]    last_x, last_y;
  logic [IX_W-1:0]      ix, iy;

  // Last usable index for a size register; zero acts as one, oversize as the store size.
  function automatic logic [SIDX_W-1:0] last_of(input logic [CFG_DIM_W-1:0] d);
    logic [SIDX_W-1:0] res;
    if (d == '0) begin
      res = '0;
    end else if (32'(d) > 32'(MAX_SRC_DIM)) begin
      res = SIDX_W'(MAX_SRC_DIM - 1);
    end else begin
      res = SIDX_W'(d - CFG_DIM_W'(1));
    end
    return res;
  endfunction

  function automatic logic [SIDX_W-1:0] clamp_idx(input logic [CMP_W-1:0] i,
                                                  input logic [SIDX_W-1:0] last);
    logic [SIDX_W-1:0] res;
    if (i > CMP_W'(last)) begin
      res = last;
    end else begin
      res = SIDX_W'(i);
    end
    return res;
  endfunction

  assign last_x = last_of(width_i);
  assign last_y = last_of(height_i);
  assign ix     = posx_r[POS_W-1:FRAC_BITS];
  assign iy     = posy_r[POS_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (ctl_i.mul_en) begin
      posx_r <= POS_W'(dst_col_i) * POS_W'(step_i);
      posy_r <= POS_W'(dst_row_i) * POS_W'(step_i);
    end
    if (ctl_i.clamp_en) begin
      x0_r <= clamp_idx(CMP_W'(ix), last_x);
      x1_r <= clamp_idx(CMP_W'(ix) + CMP_W'(1), last_x);
      y0_r <= clamp_idx(CMP_W'(iy), last_y);
      y1_r <= clamp_idx(CMP_W'(iy) + CMP_W'(1), last_y);
      fx_r <= posx_r[FRAC_BITS-1:0];
      fy_r <= posy_r[FRAC_BITS-1:0];
    end
  end

  always_comb begin
    case (nb_sel_i)
      NB_00:   rd_addr_o = {y0_r, x0_r};
      NB_01:   rd_addr_o = {y0_r, x1_r};
      NB_10:   rd_addr_o = {y1_r, x0_r};
      NB_11:   rd_addr_o = {y1_r, x1_r};
      default: rd_addr_o = {y0_r, x0_r};
    endcase
  end

  assign fx_o = fx_r;
  assign fy_o = fy_r;

endmodule

FILE: hdl/bis_blend.sv
// Four-neighbor weighted blend with truncation or round half up.
module bis_blend import bis_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  bis_ctl_t             ctl_i,
  input  logic [PIX_W-1:0]     rd_data_i,
  input  logic [FRAC_BITS-1:0] fx_i,
  input  logic [FRAC_BITS-1:0] fy_i,
  input  logic                 round_i,
  output logic [PIX_W-1:0]     pixel_o
);

  localparam int W_W    = FRAC_BITS + 1;
  localparam int PROD_W = PIX_W + W_W;
  localparam int TOP_W  = PIX_W + FRAC_BITS;
  localparam int ACC_W  = PIX_W + 2 * FRAC_BITS + 1;
  localparam int VAL_W  = ACC_W - 2 * FRAC_BITS;

  localparam logic [W_W-1:0]   ONE_W = W_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF  = ACC_W'(1) << (2 * FRAC_BITS - 1);

  logic [PIX_W-1:0]  p_r [4];
  logic [TOP_W-1:0]  top_r, bot_r;
  logic [ACC_W-1:0]  acc_r;
  logic [W_W-1:0]    wx0, wx1, wy0, wy1;
  logic [PROD_W-1:0] row_sum;
  logic [VAL_W-1:0]  val;

  assign wx1 = W_W'(fx_i);
  assign wx0 = ONE_W - wx1;
  assign wy1 = W_W'(fy_i);
  assign wy0 = ONE_W - wy1;

  // One row blend unit, shared by the top row and then the bottom row.
  always_comb begin
    if (ctl_i.top_en) begin
      row_sum = PROD_W'(p_r[0]) * PROD_W'(wx0) + PROD_W'(p_r[1]) * PROD_W'(wx1);
    end else begin
      row_sum = PROD_W'(p_r[2]) * PROD_W'(wx0) + PROD_W'(p_r[3]) * PROD_W'(wx1);
    end
  end

  always_ff @(posedge clk) begin
    // Neighbors arrive in read order; after four shifts the first sits in p_r[0].
    if (ctl_i.shift_en) begin
      p_r[0] <= p_r[1];
      p_r[1] <= p_r[2];
      p_r[2] <= p_r[3];
      p_r[3] <= rd_data_i;
    end
    if (ctl_i.top_en) begin
      top_r <= TOP_W'(row_sum);
    end
    if (ctl_i.bot_en) begin
      bot_r <= TOP_W'(row_sum);
    end
    if (ctl_i.acc0_en) begin
      acc_r <= ACC_W'(top_r) * ACC_W'(wy0);
    end else if (ctl_i.acc1_en) begin
      acc_r <= acc_r + ACC_W'(bot_r) * ACC_W'(wy1) + (round_i ? HALF : '0);
    end
  end

  assign val     = acc_r[ACC_W-1:2*FRAC_BITS];
  assign pixel_o = (val > VAL_W'(PIX_MAX)) ? PIX_MAX : val[PIX_W-1:0];

endmodule

FILE: hdl/bilinear_image_scaler_unit.sv
// Top level of the bilinear scaler: sequencer, configuration and result register.
//
//   channel  ports                                        handshake
//   input    in_kind in_pixel_in in_src_col/row in_dst_*  start & !busy
//   result   out_pixel_out out_col out_row                out_valid, one cycle
//   config   cfg_index cfg_data                           cfg_valid & cfg_ready
//
// A load item is written at the accepting edge and busy stays low. A request item holds
// busy through MUL, CLAMP, RD, DRAIN, TOP, BOT, ACC0, ACC1 and FIN, and its result strobe
// is registered from FIN; the four neighbor reads share the single read port of the frame
// store, one per cycle. A request outside the destination range is dropped and gives no
// result. Reset restores the configuration registers; the frame store is not cleared.
// The receiver cannot stall; cfg_ready is low while a request is in flight.
`include "bilinear_image_scaler_unit_defines.svh"

module bilinear_image_scaler_unit import bis_pkg::*; #(
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = MAX_DST_DIM_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int SIDX_W     = $clog2(MAX_SRC_DIM),
  localparam int DST_W      = $clog2(MAX_DST_DIM)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [PIX_W-1:0]      in_pixel_in,
  input  logic [SIDX_W-1:0]     in_src_col,
  input  logic [SIDX_W-1:0]     in_src_row,
  input  logic [DST_W-1:0]      in_dst_col,
  input  logic [DST_W-1:0]      in_dst_row,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_pixel_out,
  output logic [DST_W-1:0]      out_col,
  output logic [DST_W-1:0]      out_row,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [STEP_W-1:0]     cfg_data
);

  localparam int ADDR_W = 2 * SIDX_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_CLAMP = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_DRAIN = 4'd4;
  localparam logic [3:0] ST_TOP   = 4'd5;
  localparam logic [3:0] ST_BOT   = 4'd6;
  localparam logic [3:0] ST_ACC0  = 4'd7;
  localparam logic [3:0] ST_ACC1  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0]           state_r, state_nxt;
  logic [1:0]           rd_k_r;
  logic                 rd_vld_r;
  logic                 out_valid_r;
  logic [CFG_DIM_W-1:0] width_r, height_r;
  logic [STEP_W-1:0]    step_r;
  logic                 round_r;
  logic [DST_W-1:0]     dst_col_r, dst_row_r;
  logic [PIX_W-1:0]     out_pixel_r;
  logic [DST_W-1:0]     out_col_r, out_row_r;

  logic                 accept, req_ok, load_ok;
  logic                 mem_wr_en, mem_rd_en, rd_done;
  logic [ADDR_W-1:0]    mem_rd_addr;
  logic [PIX_W-1:0]     mem_rd_data;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [PIX_W-1:0]     blend_pixel;
  bis_ctl_t             ctl;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign load_ok   = (32'(in_src_col) < 32'(MAX_SRC_DIM)) &&
                     (32'(in_src_row) < 32'(MAX_SRC_DIM));
  assign req_ok    = accept && (in_kind == KIND_REQ) &&
                     (32'(in_dst_col) < 32'(MAX_DST_DIM)) &&
                     (32'(in_dst_row) < 32'(MAX_DST_DIM));
  assign mem_wr_en = accept && (in_kind == KIND_LOAD) && load_ok;
  assign mem_rd_en = (state_r == ST_RD);
  assign rd_done   = mem_rd_en && (rd_k_r == NB_11);
  assign cfg_ready = !busy;

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    ctl.shift_en = rd_vld_r;
    case (state_r)
      ST_IDLE: begin
        if (req_ok) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = ST_CLAMP;
      end
      ST_CLAMP: begin
        ctl.clamp_en = 1'b1;
        state_nxt    = ST_RD;
      end
      ST_RD: begin
        if (rd_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_TOP;
      ST_TOP: begin
        ctl.top_en = 1'b1;
        state_nxt  = ST_BOT;
      end
      ST_BOT: begin
        ctl.bot_en = 1'b1;
        state_nxt  = ST_ACC0;
      end
      ST_ACC0: begin
        ctl.acc0_en = 1'b1;
        state_nxt   = ST_ACC1;
      end
      ST_ACC1: begin
        ctl.acc1_en = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_k_r      <= NB_00;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      step_r      <= STEP_RST;
      round_r     <= ROUND_RST;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= mem_rd_en;
      out_valid_r <= (state_r == ST_FIN);
      if (mem_rd_en) begin
        rd_k_r <= rd_k_r + 2'd1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SRC_WIDTH:  width_r  <= cfg_data[CFG_DIM_W-1:0];
          CFG_SRC_HEIGHT: height_r <= cfg_data[CFG_DIM_W-1:0];
          CFG_STEP:       step_r   <= cfg_data;
          CFG_ROUND:      round_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ok) begin
      dst_col_r <= in_dst_col;
      dst_row_r <= in_dst_row;
    end
    if (state_r == ST_FIN) begin
      out_pixel_r <= blend_pixel;
      out_col_r   <= dst_col_r;
      out_row_r   <= dst_row_r;
    end
  end

  bis_frame_mem #(
    .ADDR_W (ADDR_W)
  ) u_frame_mem (
    .clk       (clk),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i ({in_src_row, in_src_col}),
    .wr_data_i (in_pixel_in),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  bis_addr_gen #(
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .MAX_DST_DIM (MAX_DST_DIM),
    .FRAC_BITS   (FRAC_BITS)
  ) u_addr_gen (
    .clk       (clk),
    .ctl_i     (ctl),
    .dst_col_i (dst_col_r),
    .dst_row_i (dst_row_r),
    .step_i    (step_r),
    .width_i   (width_r),
    .height_i  (height_r),
    .nb_sel_i  (rd_k_r),
    .rd_addr_o (mem_rd_addr),
    .fx_o      (fx),
    .fy_o      (fy)
  );

  bis_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .ctl_i     (ctl),
    .rd_data_i (mem_rd_data),
    .fx_i      (fx),
    .fy_i      (fy),
    .round_i   (round_r),
    .pixel_o   (blend_pixel)
  );

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_col       = out_col_r;
  assign out_row       = out_row_r;

  `BIS_ASSERT(a_no_rw_clash, !(mem_rd_en && mem_wr_en), "frame store read and write clash")
  `BIS_ASSERT_NEXT(a_fin_strobe, state_r == ST_FIN, out_valid_r, "finished item gave no strobe")
  `BIS_ASSERT_NEXT(a_single_strobe, out_valid_r, !out_valid_r, "strobe longer than a cycle")
  `BIS_ASSERT_NEXT(a_four_reads, rd_done, state_r == ST_DRAIN, "read burst did not end")

endmodule
